// ===== hw/rtl/nlpa_pkg.sv =====
// shared types and constants of the nand log page allocator
// depends on nothing; imported by the allocator top level

package nlpa_pkg;

   // default geometry of the log region
   localparam int PAGE_BYTES_DEF      = 2048;
   localparam int BLOCK_PAGES_DEF     = 64;
   localparam int TOTAL_BLOCKS_DEF    = 1024;
   localparam int MAX_RECORD_DEF      = 256;

   // field widths of the streams
   localparam int ACTION_W  = 3;
   localparam int LENGTH_W  = 9;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int ADDR_W    = 16;
   localparam int OFFSET_W  = 11;
   localparam int WRCNT_W   = 16;
   localparam int FAILCNT_W = 11;
   localparam int CFG_W     = 10;
   localparam int COND_W    = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 88;

   localparam logic [CFG_W-1:0] FIRST_BLOCK_RESET = 10'd4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_START      = 3'd0,
      ACT_APPEND     = 3'd1,
      ACT_FLUSH      = 3'd2,
      ACT_ERASE_DONE = 3'd3,
      ACT_PROG_DONE  = 3'd4
   } action_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE    = 2'd0,
      CMD_ERASE   = 2'd1,
      CMD_PROGRAM = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_WAIT      = 3'd0,
      ST_PLACED    = 3'd1,
      ST_FLUSHED   = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_READY     = 3'd4,
      ST_BAD_LEN   = 3'd5,
      ST_FULL      = 3'd6,
      ST_NOT_READY = 3'd7
   } status_type;

   typedef enum logic [COND_W-1:0] {
      COND_UNKNOWN = 2'd0,
      COND_ERASED  = 2'd1,
      COND_BAD     = 2'd2
   } cond_type;

endpackage

// ===== hw/rtl/nand_log_page_allocator.sv =====
// Append-only NAND log allocator. A transfer on req carries an action (start, append record,
// flush page, erase finished, program finished); each one yields exactly one transfer on rsp
// with the device command, status, row address, record offset, counters and the full flag.
// Block conditions (unknown, erased, bad) live in a TOTAL_BLOCKS x 2 ram. After reset and
// after every start the block runs a clearing pass over every entry of that ram and
// takes no request meanwhile; the start's own response is produced before the pass. A plain
// request goes through accept, execute and respond. An action that has to look for the next
// usable block adds a ram read, then a check, for every block visited. The response sits in
// an output register, so the next request is taken while it waits. csr_wr_data sets the first
// block of the region; it takes effect at the next start (and is 4 after reset).
// depends on nlpa_pkg and nlpa_ram

module nand_log_page_allocator import nlpa_pkg::*; #(
   parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
   parameter int BLOCK_PAGES     = BLOCK_PAGES_DEF,
   parameter int TOTAL_BLOCKS    = TOTAL_BLOCKS_DEF,
   parameter int MAX_RECORD      = MAX_RECORD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,    // first_log_block
   // requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ACTION_W-1:0]   req_tuser,      // action
   input  logic [REQ_DATA_W-1:0] req_tdata,      // record_length[8:0], op_ok[9], zero pad
   // responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata       // command[1:0], status[4:2],
                                                 // page_address[20:5], write_offset[31:21],
                                                 // written_page_count[47:32],
                                                 // bad_block_total[58:48],
                                                 // erase_fail_total[69:59],
                                                 // program_fail_total[80:70],
                                                 // region_full[81], zero pad
);

   localparam int BLK_LIM = (TOTAL_BLOCKS + 1 > (1 << CFG_W)) ? TOTAL_BLOCKS + 1 : (1 << CFG_W);
   localparam int BLK_W   = $clog2(BLK_LIM);
   localparam int IDX_W   = $clog2(TOTAL_BLOCKS);
   localparam int PG_W    = $clog2(BLOCK_PAGES);
   localparam int FILL_W  = $clog2(PAGE_BYTES + 1);
   localparam int ROW_W   = BLK_W + PG_W + 2;
   localparam int PAD_W   = RSP_DATA_W - (CMD_W + STATUS_W + ADDR_W + OFFSET_W + WRCNT_W
                                          + 3 * FAILCNT_W + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_WALK_RD, S_WALK_CHK, S_EMIT
   } state_type;

   typedef enum logic [1:0] {P_IDLE, P_ERASE, P_PROG} pend_type;
   typedef enum logic [1:0] {C_START, C_APPEND, C_FLUSH} ctx_type;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       fbl_ff, fbl_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [PG_W-1:0]        pg_ff, pg_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [LENGTH_W-1:0]    plen_ff, plen_in;
   pend_type               pend_ff, pend_in;
   ctx_type                ctx_ff, ctx_in;
   logic                   ready_ff, ready_in;
   logic                   full_ff, full_in;
   logic [WRCNT_W-1:0]     cnt_wr_ff, cnt_wr_in;
   logic [FAILCNT_W-1:0]   cnt_bad_ff, cnt_bad_in;
   logic [FAILCNT_W-1:0]   cnt_ef_ff, cnt_ef_in;
   logic [FAILCNT_W-1:0]   cnt_pf_ff, cnt_pf_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   action_type             act_ff, act_in;
   logic [LENGTH_W-1:0]    len_ff, len_in;
   logic                   ok_ff, ok_in;
   cmd_type                res_cmd_ff, res_cmd_in;
   status_type             res_st_ff, res_st_in;
   logic [OFFSET_W-1:0]    res_off_ff, res_off_in;
   logic                   go_clear_ff, go_clear_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [COND_W-1:0]      ram_wr_data;
   logic                   ram_rd_en;
   logic [COND_W-1:0]      ram_rd_data;

   logic [ROW_W-1:0]       row_base;
   logic [ROW_W-1:0]       row_page;
   logic [ADDR_W-1:0]      emit_addr;
   logic [FILL_W:0]        fill_sum;
   logic                   blk_out;

   nlpa_ram #(
      .WIDTH (COND_W),
      .DEPTH (TOTAL_BLOCKS)
   ) u_cond_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (blk_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign row_base = ROW_W'(blk_ff) * ROW_W'(BLOCK_PAGES);
   assign row_page = row_base + ROW_W'(pg_ff);
   assign fill_sum = (FILL_W + 1)'(fill_ff) + (FILL_W + 1)'(len_ff);
   assign blk_out  = (blk_ff >= BLK_W'(TOTAL_BLOCKS));

   always_comb begin
      case (res_cmd_ff)
         CMD_ERASE:   emit_addr = row_base[ADDR_W-1:0];
         CMD_PROGRAM: emit_addr = row_page[ADDR_W-1:0];
         default:     emit_addr = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      fbl_in       = csr_wr_en ? csr_wr_data : fbl_ff;
      blk_in       = blk_ff;
      pg_in        = pg_ff;
      fill_in      = fill_ff;
      plen_in      = plen_ff;
      pend_in      = pend_ff;
      ctx_in       = ctx_ff;
      ready_in     = ready_ff;
      full_in      = full_ff;
      cnt_wr_in    = cnt_wr_ff;
      cnt_bad_in   = cnt_bad_ff;
      cnt_ef_in    = cnt_ef_ff;
      cnt_pf_in    = cnt_pf_ff;
      clr_in       = clr_ff;
      act_in       = act_ff;
      len_in       = len_ff;
      ok_in        = ok_ff;
      res_cmd_in   = res_cmd_ff;
      res_st_in    = res_st_ff;
      res_off_in   = res_off_ff;
      go_clear_in  = go_clear_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = blk_ff[IDX_W-1:0];
      ram_wr_data  = COND_UNKNOWN;
      ram_rd_en    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = COND_UNKNOWN;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TOTAL_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = action_type'(req_tuser);
               len_in   = req_tdata[LENGTH_W-1:0];
               ok_in    = req_tdata[LENGTH_W];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_cmd_in  = CMD_NONE;
            res_st_in   = ST_WAIT;
            res_off_in  = '0;
            go_clear_in = 1'b0;
            state_in    = S_EMIT;
            case (act_ff)
               ACT_START: begin
                  // table reads all unknown after the pass, so the first block needs an erase
                  cnt_wr_in   = '0;
                  cnt_bad_in  = '0;
                  cnt_ef_in   = '0;
                  cnt_pf_in   = '0;
                  fill_in     = '0;
                  plen_in     = '0;
                  ready_in    = 1'b0;
                  blk_in      = BLK_W'(fbl_ff);
                  pg_in       = '0;
                  go_clear_in = 1'b1;
                  clr_in      = '0;
                  ctx_in      = C_START;
                  if (BLK_W'(fbl_ff) >= BLK_W'(TOTAL_BLOCKS)) begin
                     full_in   = 1'b1;
                     pend_in   = P_IDLE;
                     res_st_in = ST_FULL;
                  end else begin
                     full_in    = 1'b0;
                     pend_in    = P_ERASE;
                     res_cmd_in = CMD_ERASE;
                  end
               end

               ACT_APPEND: begin
                  if (!ready_ff) begin
                     res_st_in = ST_NOT_READY;
                  end else if (pend_ff != P_IDLE) begin
                     res_st_in = ST_WAIT;
                  end else if (full_ff) begin
                     res_st_in = ST_FULL;
                  end else if (len_ff == '0 ||
                               {1'b0, len_ff} > (LENGTH_W + 1)'(MAX_RECORD)) begin
                     res_st_in = ST_BAD_LEN;
                  end else if (fill_sum > (FILL_W + 1)'(PAGE_BYTES)) begin
                     plen_in  = len_ff;
                     ctx_in   = C_APPEND;
                     state_in = S_WALK_RD;
                  end else begin
                     res_off_in = OFFSET_W'(fill_ff);
                     fill_in    = fill_sum[FILL_W-1:0];
                     res_st_in  = ST_PLACED;
                  end
               end

               ACT_FLUSH: begin
                  if (!ready_ff) begin
                     res_st_in = ST_NOT_READY;
                  end else if (pend_ff != P_IDLE) begin
                     res_st_in = ST_WAIT;
                  end else if (fill_ff == '0) begin
                     res_st_in = ST_EMPTY;
                  end else begin
                     ctx_in   = C_FLUSH;
                     state_in = S_WALK_RD;
                  end
               end

               ACT_ERASE_DONE: begin
                  if (pend_ff == P_ERASE) begin
                     pend_in   = P_IDLE;
                     ram_wr_en = 1'b1;
                     state_in  = S_WALK_RD;
                     if (ok_ff) begin
                        ram_wr_data = COND_ERASED;
                     end else begin
                        ram_wr_data = COND_BAD;
                        if (cnt_bad_ff != '1) cnt_bad_in = cnt_bad_ff + 1'b1;
                        if (cnt_ef_ff != '1) cnt_ef_in = cnt_ef_ff + 1'b1;
                        blk_in = blk_ff + 1'b1;
                        pg_in  = '0;
                     end
                  end
               end

               ACT_PROG_DONE: begin
                  if (pend_ff == P_PROG) begin
                     pend_in = P_IDLE;
                     if (ok_ff) begin
                        if (pg_ff == PG_W'(BLOCK_PAGES - 1)) begin
                           pg_in  = '0;
                           blk_in = blk_ff + 1'b1;
                        end else begin
                           pg_in = pg_ff + 1'b1;
                        end
                        if (cnt_wr_ff != '1) cnt_wr_in = cnt_wr_ff + 1'b1;
                        if (ctx_ff == C_APPEND) begin
                           fill_in   = FILL_W'(plen_ff);
                           res_st_in = ST_PLACED;
                        end else begin
                           fill_in   = '0;
                           res_st_in = ST_FLUSHED;
                        end
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = COND_BAD;
                        if (cnt_bad_ff != '1) cnt_bad_in = cnt_bad_ff + 1'b1;
                        if (cnt_pf_ff != '1) cnt_pf_in = cnt_pf_ff + 1'b1;
                        blk_in   = blk_ff + 1'b1;
                        pg_in    = '0;
                        state_in = S_WALK_RD;
                     end
                  end
               end

               default: begin
               end
            endcase
         end

         S_WALK_RD: begin
            if (blk_out) begin
               full_in   = 1'b1;
               pend_in   = P_IDLE;
               res_st_in = ST_FULL;
               state_in  = S_EMIT;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            state_in = S_EMIT;
            case (cond_type'(ram_rd_data))
               COND_BAD: begin
                  blk_in   = blk_ff + 1'b1;
                  pg_in    = '0;
                  state_in = S_WALK_RD;
               end
               COND_ERASED: begin
                  if (ctx_ff == C_START) begin
                     ready_in  = 1'b1;
                     res_st_in = ST_READY;
                  end else begin
                     pend_in    = P_PROG;
                     res_cmd_in = CMD_PROGRAM;
                  end
               end
               default: begin
                  pend_in    = P_ERASE;
                  res_cmd_in = CMD_ERASE;
               end
            endcase
         end

         S_EMIT: begin
            // output register free or being emptied in this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, full_ff, cnt_pf_ff, cnt_ef_ff, cnt_bad_ff,
                               cnt_wr_ff, res_off_ff, emit_addr, res_st_ff, res_cmd_ff};
               state_in     = go_clear_ff ? S_CLEAR : S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fbl_ff       <= FIRST_BLOCK_RESET;
         blk_ff       <= BLK_W'(FIRST_BLOCK_RESET);
         pg_ff        <= '0;
         fill_ff      <= '0;
         plen_ff      <= '0;
         pend_ff      <= P_IDLE;
         ctx_ff       <= C_START;
         ready_ff     <= 1'b0;
         full_ff      <= 1'b0;
         cnt_wr_ff    <= '0;
         cnt_bad_ff   <= '0;
         cnt_ef_ff    <= '0;
         cnt_pf_ff    <= '0;
         clr_ff       <= '0;
         go_clear_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fbl_ff       <= fbl_in;
         blk_ff       <= blk_in;
         pg_ff        <= pg_in;
         fill_ff      <= fill_in;
         plen_ff      <= plen_in;
         pend_ff      <= pend_in;
         ctx_ff       <= ctx_in;
         ready_ff     <= ready_in;
         full_ff      <= full_in;
         cnt_wr_ff    <= cnt_wr_in;
         cnt_bad_ff   <= cnt_bad_in;
         cnt_ef_ff    <= cnt_ef_in;
         cnt_pf_ff    <= cnt_pf_in;
         clr_ff       <= clr_in;
         go_clear_ff  <= go_clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      len_ff      <= len_in;
      ok_ff       <= ok_in;
      res_cmd_ff  <= res_cmd_in;
      res_st_ff   <= res_st_in;
      res_off_ff  <= res_off_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/nlpa_ram.sv =====
// generic single write port, single read port ram with registered read data
// depends on nothing

module nlpa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/nlpa_tb_pkg.sv =====
// predictor and response scoreboard for the nand log page allocator testbench
// depends on nlpa_pkg; imported by the testbench top module

package nlpa_tb_pkg;
   import nlpa_pkg::*;

   localparam int unsigned REGION_END = TOTAL_BLOCKS_DEF * BLOCK_PAGES_DEF;

   // action codes that the block has to ignore
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

   typedef enum logic [2:0] {
      PEND_IDLE,
      PEND_ERASE_START,
      PEND_ERASE_APPEND,
      PEND_ERASE_FLUSH,
      PEND_PROG_APPEND,
      PEND_PROG_FLUSH
   } pend_code;

   typedef enum logic [1:0] {
      CTX_START,
      CTX_APPEND,
      CTX_FLUSH
   } flow_ctx;

   typedef enum logic [1:0] {
      SEARCH_READY,
      SEARCH_ERASE,
      SEARCH_FULL
   } search_result;

   typedef struct packed {
      cmd_type                command;
      status_type             status;
      logic [ADDR_W-1:0]      page_address;
      logic [OFFSET_W-1:0]    write_offset;
      logic [WRCNT_W-1:0]     pages_written;
      logic [FAILCNT_W-1:0]   bad_count;
      logic [FAILCNT_W-1:0]   erase_fails;
      logic [FAILCNT_W-1:0]   program_fails;
      logic                   region_full;
   } log_response;

   class log_scoreboard;
      logic [CFG_W-1:0]       first_block;
      cond_type               block_state [TOTAL_BLOCKS_DEF];
      logic [16:0]            next_page;
      logic [11:0]            fill;
      logic [LENGTH_W-1:0]    held_len;
      pend_code               pend;
      bit                     ready;
      bit                     full;
      logic [WRCNT_W-1:0]     pages_written;
      logic [FAILCNT_W-1:0]   bad_count;
      logic [FAILCNT_W-1:0]   erase_fails;
      logic [FAILCNT_W-1:0]   program_fails;
      log_response            outcome;
      log_response            due [$];
      int                     errors;
      int                     seen;

      function new();
         first_block = FIRST_BLOCK_RESET;
         clear_state();
         errors = 0;
         seen = 0;
      endfunction

      function void clear_state();
         foreach (block_state[i]) block_state[i] = COND_UNKNOWN;
         pages_written = '0;
         bad_count = '0;
         erase_fails = '0;
         program_fails = '0;
         fill = '0;
         held_len = '0;
         pend = PEND_IDLE;
         full = 1'b0;
         ready = 1'b0;
         next_page = 17'(first_block * BLOCK_PAGES_DEF);
      endfunction

      // skip bad blocks; unknown blocks need an erase first
      function search_result find_block();
         int unsigned blk;
         while (next_page < REGION_END) begin
            blk = next_page / BLOCK_PAGES_DEF;
            if (block_state[blk] == COND_BAD) begin
               next_page = 17'((blk + 1) * BLOCK_PAGES_DEF);
               continue;
            end
            if (block_state[blk] != COND_ERASED) return SEARCH_ERASE;
            return SEARCH_READY;
         end
         full = 1'b1;
         return SEARCH_FULL;
      endfunction

      function void retire_block(bit erase_failed);
         int unsigned blk;
         blk = next_page / BLOCK_PAGES_DEF;
         if (blk < TOTAL_BLOCKS_DEF && block_state[blk] != COND_BAD) begin
            block_state[blk] = COND_BAD;
            if (bad_count != '1) bad_count++;
         end
         if (erase_failed) begin
            if (erase_fails != '1) erase_fails++;
         end else begin
            if (program_fails != '1) program_fails++;
         end
         next_page = 17'((blk + 1) * BLOCK_PAGES_DEF);
      endfunction

      function void advance(flow_ctx ctx);
         int unsigned blk;
         case (find_block())
            SEARCH_ERASE: begin
               blk = next_page / BLOCK_PAGES_DEF;
               outcome.command = CMD_ERASE;
               outcome.page_address = ADDR_W'(blk * BLOCK_PAGES_DEF);
               outcome.status = ST_WAIT;
               pend = pend_code'(PEND_ERASE_START + ctx);
            end
            SEARCH_FULL: begin
               outcome.status = ST_FULL;
               pend = PEND_IDLE;
            end
            default: begin
               if (ctx == CTX_START) begin
                  ready = 1'b1;
                  outcome.status = ST_READY;
               end else begin
                  outcome.command = CMD_PROGRAM;
                  outcome.page_address = next_page[ADDR_W-1:0];
                  outcome.status = ST_WAIT;
                  pend = (ctx == CTX_APPEND) ? PEND_PROG_APPEND : PEND_PROG_FLUSH;
               end
            end
         endcase
      endfunction

      // called for every accepted request transfer
      function void note(logic [ACTION_W-1:0] act, logic [LENGTH_W-1:0] len, logic ok);
         flow_ctx ctx;
         int unsigned blk;
         outcome = '0;
         outcome.command = CMD_NONE;
         outcome.status = ST_WAIT;
         case (act)
            ACT_START: begin
               clear_state();
               advance(CTX_START);
            end
            ACT_APPEND: begin
               if (!ready) outcome.status = ST_NOT_READY;
               else if (pend != PEND_IDLE) outcome.status = ST_WAIT;
               else if (full) outcome.status = ST_FULL;
               else if (len == 0 || len > MAX_RECORD_DEF) outcome.status = ST_BAD_LEN;
               else if (fill + len > PAGE_BYTES_DEF) begin
                  held_len = len;
                  advance(CTX_APPEND);
               end else begin
                  outcome.write_offset = fill[OFFSET_W-1:0];
                  fill += len;
                  outcome.status = ST_PLACED;
               end
            end
            ACT_FLUSH: begin
               if (!ready) outcome.status = ST_NOT_READY;
               else if (pend != PEND_IDLE) outcome.status = ST_WAIT;
               else if (fill == 0) outcome.status = ST_EMPTY;
               else advance(CTX_FLUSH);
            end
            ACT_ERASE_DONE: begin
               if (pend inside {PEND_ERASE_START, PEND_ERASE_APPEND, PEND_ERASE_FLUSH}) begin
                  ctx = flow_ctx'(pend - PEND_ERASE_START);
                  blk = next_page / BLOCK_PAGES_DEF;
                  pend = PEND_IDLE;
                  if (ok) begin
                     if (blk < TOTAL_BLOCKS_DEF) block_state[blk] = COND_ERASED;
                  end else begin
                     retire_block(1'b1);
                  end
                  advance(ctx);
               end
            end
            ACT_PROG_DONE: begin
               if (pend inside {PEND_PROG_APPEND, PEND_PROG_FLUSH}) begin
                  ctx = (pend == PEND_PROG_APPEND) ? CTX_APPEND : CTX_FLUSH;
                  pend = PEND_IDLE;
                  if (ok) begin
                     next_page++;
                     if (pages_written != '1) pages_written++;
                     fill = '0;
                     if (ctx == CTX_APPEND) begin
                        // the record that forced the program opens the new page
                        fill = 12'(held_len);
                        outcome.status = ST_PLACED;
                     end else begin
                        outcome.status = ST_FLUSHED;
                     end
                  end else begin
                     retire_block(1'b0);
                     advance(ctx);
                  end
               end
            end
            default: ;
         endcase
         outcome.pages_written = pages_written;
         outcome.bad_count = bad_count;
         outcome.erase_fails = erase_fails;
         outcome.program_fails = program_fails;
         outcome.region_full = full;
         due.push_back(outcome);
      endfunction

      function void compare(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      // called for every accepted response transfer
      function void check(logic [RSP_DATA_W-1:0] d);
         log_response want;
         seen++;
         if (due.size() == 0) begin
            $display("%0t: response %0h expected none, got one", $time, d);
            errors++;
            return;
         end
         want = due.pop_front();
         compare("command", want.command, d[1:0]);
         compare("status", want.status, d[4:2]);
         compare("page_address", want.page_address, d[20:5]);
         compare("write_offset", want.write_offset, d[31:21]);
         compare("written_page_count", want.pages_written, d[47:32]);
         compare("bad_block_total", want.bad_count, d[58:48]);
         compare("erase_fail_total", want.erase_fails, d[69:59]);
         compare("program_fail_total", want.program_fails, d[80:70]);
         compare("region_full", want.region_full, d[81]);
      endfunction
   endclass

endpackage

// ===== test/testbench.sv =====
// top module of the nand log page allocator testbench: directed and random requests with
// random idling on both sides, region register changes between phases, final verdict
// depends on nlpa_pkg, nlpa_tb_pkg and the allocator rtl

module testbench;
   import nlpa_pkg::*;
   import nlpa_tb_pkg::*;

   localparam int PHASES           = 6;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int STALL_LIMIT      = 20000;
   localparam int LONG_HOLD        = 300;
   localparam int HOLD_AT          = 150;
   localparam int TAIL_CYCLES      = 32;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CFG_W-1:0]      csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ACTION_W-1:0]   req_tuser;      // action
   logic [REQ_DATA_W-1:0] req_tdata;      // record_length[8:0], op_ok[9], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;      // command, status, page_address, write_offset,
                                          // counters, region_full from bit 0 up

   log_scoreboard sb;
   bit            last_part = 1'b0;
   int            quiet_cycles = 0;

   nand_log_page_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send(input logic [ACTION_W-1:0] act, input logic [LENGTH_W-1:0] len,
                       input logic ok);
      if (!last_part && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= REQ_DATA_W'({ok, len});
      do @(posedge clock); while (!req_tready);
      sb.note(act, len, ok);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [ACTION_W-1:0] act;
      logic [LENGTH_W-1:0] len;
      logic                ok;
      logic [CFG_W-1:0]    setting;
      int                  roll;
      sb = new();
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // before any start, then stray completions and unused codes
      send(ACT_APPEND, 9'd10, 1'b1);
      send(ACT_FLUSH, 9'd0, 1'b1);
      send(ACT_ERASE_DONE, 9'd0, 1'b1);
      send(ACT_PROG_DONE, 9'd0, 1'b0);
      send(ACT_UNUSED_HI, 9'd511, 1'b1);
      send(ACT_UNUSED_LO, 9'd0, 1'b0);
      send(ACT_START, 9'd0, 1'b0);
      send(ACT_APPEND, 9'd20, 1'b1);        // device still busy
      send(ACT_ERASE_DONE, 9'd0, 1'b1);
      send(ACT_FLUSH, 9'd0, 1'b1);          // empty buffer
      send(ACT_APPEND, 9'd0, 1'b1);
      send(ACT_APPEND, 9'd257, 1'b1);
      send(ACT_APPEND, 9'd511, 1'b1);
      send(ACT_APPEND, 9'd1, 1'b1);
      send(ACT_FLUSH, 9'd0, 1'b1);
      send(ACT_PROG_DONE, 9'd0, 1'b0);      // program fails, next block gets erased
      send(ACT_ERASE_DONE, 9'd0, 1'b0);     // and that erase fails too
      send(ACT_ERASE_DONE, 9'd0, 1'b1);
      send(ACT_PROG_DONE, 9'd0, 1'b1);
      // fill the page exactly, then overflow it
      repeat (9) send(ACT_APPEND, 9'd256, 1'b1);
      send(ACT_PROG_DONE, 9'd0, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         // a start is followed by a clearing pass after its response
         repeat (TOTAL_BLOCKS_DEF + 64) @(posedge clock);
         case (ph)
            0: setting = 10'd1023;
            1: setting = 10'd0;
            2: setting = 10'd1022;
            3: setting = CFG_W'($urandom_range(0, 1023));
            4: setting = 10'd1021;
            default: setting = FIRST_BLOCK_RESET;
         endcase
         last_part = (ph == PHASES - 1);
         csr_wr_en <= 1'b1;
         csr_wr_data <= setting;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         sb.first_block = setting;
         send(ACT_START, LENGTH_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
         repeat (RANDOM_PER_PHASE) begin
            len = ($urandom_range(0, 15) == 0) ? LENGTH_W'($urandom_range(0, 511))
                                               : LENGTH_W'($urandom_range(1, MAX_RECORD_DEF));
            ok = ($urandom_range(0, 9) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 4)
               act = ACTION_W'($urandom_range(ACT_ERASE_DONE, ACT_UNUSED_HI));
            else if (roll < 5)
               act = ACT_START;
            else if (sb.pend inside {PEND_ERASE_START, PEND_ERASE_APPEND, PEND_ERASE_FLUSH})
               act = ACT_ERASE_DONE;
            else if (sb.pend inside {PEND_PROG_APPEND, PEND_PROG_FLUSH})
               act = ACT_PROG_DONE;
            else if (!sb.ready || sb.full)
               act = ($urandom_range(0, 3) == 0) ? ACT_START
                   : ($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_FLUSH;
            else
               act = ($urandom_range(0, 11) == 0) ? ACT_FLUSH : ACT_APPEND;
            send(act, len, ok);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // response side: short random stalls, plus one long hold that backs up the requests
   initial begin
      int  gap;
      bit  held_long;
      gap = 0;
      held_long = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_long && sb.seen >= HOLD_AT) begin
            held_long = 1'b1;
            gap = LONG_HOLD;
         end else if (gap == 0 && !last_part && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
         end
         if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
